// ----- hdl/lddt_pkg.sv -----
// Shared types for the Lucas digit domination test.
// Holds the sequencer state encoding and the control/status structs
// passed between the top level and the serial divider.
package lddt_pkg;

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_DIV   = 4'b0100,
    S_CMP   = 4'b1000
  } lddt_state_t;

  // commands from the sequencer to the divider
  typedef struct packed {
    logic load;
  } lddt_div_ctrl_t;

  // status from the divider back to the sequencer
  typedef struct packed {
    logic running;
    logic done;
  } lddt_div_stat_t;

endpackage

// ----- hdl/lddt_div.sv -----
// Dual-lane bit-serial restoring divider: divides two values by one radix.
// One quotient bit per cycle per lane; depends on lddt_pkg.
module lddt_div
  import lddt_pkg::*;
#(
  parameter int VALUE_WIDTH = 64,
  parameter int RADIX_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lddt_div_ctrl_t         ctrl,
  input  logic [VALUE_WIDTH-1:0] dvd_up,
  input  logic [VALUE_WIDTH-1:0] dvd_lo,
  input  logic [RADIX_WIDTH-1:0] divisor,
  output lddt_div_stat_t         stat,
  output logic [VALUE_WIDTH-1:0] quot_up,
  output logic [VALUE_WIDTH-1:0] quot_lo,
  output logic [RADIX_WIDTH-1:0] rem_up,
  output logic [RADIX_WIDTH-1:0] rem_lo
);

  localparam int CntW = $clog2(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0] q_up_r, q_lo_r, q_up_nxt, q_lo_nxt;
  logic [RADIX_WIDTH-1:0] r_up_r, r_lo_r, r_up_nxt, r_lo_nxt;
  logic [CntW-1:0]        cnt_r;
  logic                   run_r, done_r;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  function automatic logic [VALUE_WIDTH+RADIX_WIDTH-1:0] div_step(
    input logic [VALUE_WIDTH-1:0] q,
    input logic [RADIX_WIDTH-1:0] r,
    input logic [RADIX_WIDTH-1:0] d
  );
    logic [RADIX_WIDTH:0]   shifted;
    logic [RADIX_WIDTH:0]   diff;
    logic                   fits;
    logic [RADIX_WIDTH-1:0] r_new;
    shifted = {r, q[VALUE_WIDTH-1]};
    diff    = shifted - {1'b0, d};
    fits    = ~diff[RADIX_WIDTH];
    r_new   = fits ? diff[RADIX_WIDTH-1:0] : shifted[RADIX_WIDTH-1:0];
    return {q[VALUE_WIDTH-2:0], fits, r_new};
  endfunction

  // step both lanes
  always_comb begin
    {q_up_nxt, r_up_nxt} = div_step(q_up_r, r_up_r, divisor);
    {q_lo_nxt, r_lo_nxt} = div_step(q_lo_r, r_lo_r, divisor);
  end

  // control: bit counter and run flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.load) begin
        run_r <= 1'b1;
        cnt_r <= CntW'(VALUE_WIDTH - 1);
      end else if (run_r) begin
        cnt_r <= cnt_r - CntW'(1);
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath shift registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      q_up_r <= dvd_up;
      q_lo_r <= dvd_lo;
      r_up_r <= '0;
      r_lo_r <= '0;
    end else if (run_r) begin
      q_up_r <= q_up_nxt;
      q_lo_r <= q_lo_nxt;
      r_up_r <= r_up_nxt;
      r_lo_r <= r_lo_nxt;
    end
  end

  assign stat.running = run_r;
  assign stat.done    = done_r;
  assign quot_up      = q_up_r;
  assign quot_lo      = q_lo_r;
  assign rem_up       = r_up_r;
  assign rem_lo       = r_lo_r;

endmodule

// ----- hdl/lucas_digit_domination_test.sv -----
// Top level of the Lucas digit domination test.
// Sequencer, radix register and result register; uses lddt_pkg and lddt_div.
//
// Compares base-radix digits of in_lower_value against in_upper_value, least
// significant first, and reports whether some lower digit exceeds the upper
// one (so the binomial coefficient is divisible by a prime radix). A radix
// of 0 or 1 is used as 2. A transaction is taken when start is high and busy
// is low; exactly one result follows, shown for one cycle with out_valid and
// it cannot be stalled. Each examined digit passes through a check state that
// loads the shared bit-serial divider, VALUE_WIDTH divide steps that yield
// one quotient bit per cycle for both values at once, the divider's done
// strobe and a compare state. busy stays high over these digits, plus a
// final check when both values run out to zero, and the result shows in
// the first cycle with busy low, where the next transaction may already be
// taken. At most VALUE_WIDTH digits are examined.
// Write the radix only while busy is low.
module lucas_digit_domination_test
  import lddt_pkg::*;
#(
  parameter int VALUE_WIDTH = 64,
  parameter int RADIX_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input transaction
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] in_upper_value,
  input  logic [VALUE_WIDTH-1:0] in_lower_value,
  // result transaction
  output logic                   out_valid,
  output logic                   out_digit_exceeds,
  output logic                   out_digit_dominated,
  // radix write
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [RADIX_WIDTH-1:0] cfg_data
);

  lddt_state_t            state_r, state_nxt;
  logic [RADIX_WIDTH-1:0] radix_r, radix_eff;
  logic [VALUE_WIDTH-1:0] up_r, lo_r;
  logic                   out_valid_r, out_exc_r;
  lddt_div_ctrl_t         div_ctrl;
  lddt_div_stat_t         div_stat;
  logic [VALUE_WIDTH-1:0] quot_up, quot_lo;
  logic [RADIX_WIDTH-1:0] rem_up, rem_lo;
  logic                   both_zero, lo_gt;

  // radix register, saturated to 2 at use
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_WIDTH'(2);
    end else if (cfg_valid && cfg_ready) begin
      radix_r <= cfg_data;
    end
  end

  assign cfg_ready = (state_r == S_IDLE);
  assign radix_eff = (radix_r < RADIX_WIDTH'(2)) ? RADIX_WIDTH'(2) : radix_r;

  // shared serial divider for both values
  lddt_div #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .RADIX_WIDTH(RADIX_WIDTH)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (div_ctrl),
    .dvd_up  (up_r),
    .dvd_lo  (lo_r),
    .divisor (radix_eff),
    .stat    (div_stat),
    .quot_up (quot_up),
    .quot_lo (quot_lo),
    .rem_up  (rem_up),
    .rem_lo  (rem_lo)
  );

  assign both_zero     = (up_r == '0) && (lo_r == '0);
  assign lo_gt         = rem_lo > rem_up;
  assign div_ctrl.load = (state_r == S_CHECK) && !both_zero;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = S_CHECK;
      S_CHECK: state_nxt = both_zero ? S_IDLE : S_DIV;
      S_DIV:   if (div_stat.done) state_nxt = S_CMP;
      S_CMP:   state_nxt = lo_gt ? S_IDLE : S_CHECK;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // operands: load on accept, replace by quotients after each digit
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      up_r <= in_upper_value;
      lo_r <= in_lower_value;
    end else if (state_r == S_CMP) begin
      up_r <= quot_up;
      lo_r <= quot_lo;
    end
  end

  // result register and strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ((state_r == S_CHECK) && both_zero) || ((state_r == S_CMP) && lo_gt);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CHECK) begin
      out_exc_r <= 1'b0;
    end else if (state_r == S_CMP) begin
      out_exc_r <= lo_gt;
    end
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_digit_exceeds   = out_exc_r;
  assign out_digit_dominated = ~out_exc_r;

  // checks
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a transaction in progress");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start work");

  a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (rem_up < radix_eff) && (rem_lo < radix_eff))
    else $error("divider remainder not below radix");

  a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.running |-> (state_r == S_DIV))
    else $error("divider running outside the divide state");

endmodule
